FILE: hw/rtl/nfsa_pkg.sv
package nfsa_pkg;

    localparam int ACTION_W = 2;
    localparam int SITE_W   = 4;
    localparam int POS_W    = 16;
    localparam int CAP_W    = 16;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PLACE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] RES_NONE   = 2'd0;
    localparam logic [1:0] RES_LOAD   = 2'd1;
    localparam logic [1:0] RES_READ   = 2'd2;
    localparam logic [1:0] RES_COMMIT = 2'd3;

    typedef struct packed {
        logic       take;
        logic       wr_load;
        logic       rd_site;
        logic       scan_start;
        logic       wr_commit;
        logic       res_set;
        logic [1:0] res_sel;
        logic       out_load;
    } nfsa_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                idx_ok;
        logic                scan_busy;
        logic                out_free;
    } nfsa_status_t;

endpackage

FILE: hw/rtl/nfsa_ctrl.sv
module nfsa_ctrl
    import nfsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  nfsa_status_t status,
    output nfsa_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.action)
                    ACT_LOAD:
                    begin
                        cmd.wr_load = status.idx_ok;
                        cmd.res_set = 1'b1;
                        cmd.res_sel = status.idx_ok ? RES_LOAD : RES_NONE;
                        state_next  = ST_DONE;
                    end
                    ACT_PLACE:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    ACT_READ:
                    begin
                        if (status.idx_ok)
                        begin
                            cmd.rd_site = 1'b1;
                            state_next  = ST_RDWAIT;
                        end
                        else
                        begin
                            cmd.res_set = 1'b1;
                            cmd.res_sel = RES_NONE;
                            state_next  = ST_DONE;
                        end
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_NONE;
                        state_next  = ST_DONE;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                cmd.res_set = 1'b1;
                cmd.res_sel = RES_READ;
                state_next  = ST_DONE;
            end
            ST_SCAN:
            begin
                if (!status.scan_busy)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.wr_commit = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_sel   = RES_COMMIT;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/nfsa_datapath.sv
module nfsa_datapath
    import nfsa_pkg::*;
#(
    parameter int MAX_SITES  = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic [ACTION_W-1:0]     in_action,
    input  logic [SITE_W-1:0]       in_site_index,
    input  logic signed [POS_W-1:0] in_pos_x,
    input  logic signed [POS_W-1:0] in_pos_y,
    input  logic [CAP_W-1:0]        in_capacity,
    input  logic                    m_tready,
    input  nfsa_cmd_t               cmd,
    output nfsa_status_t            status,
    output logic                    out_valid,
    output logic                    out_found,
    output logic [SITE_W-1:0]       out_site,
    output logic [CNT_W-1:0]        out_count
);

    localparam int IDX_W  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int LIM_W  = $clog2(MAX_SITES + 1);
    localparam int CMP_W  = (LIM_W > CFG_W) ? LIM_W : CFG_W;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int DIST_W = COORD_BITS + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [CAP_W-1:0]             cap;
        logic [CNT_W-1:0]             occ;
    } entry_t;

    entry_t mem [MAX_SITES];
    logic [MAX_SITES-1:0] vld_reg;

    logic [CFG_W-1:0] sites_in_use_reg;

    // latched request
    logic [ACTION_W-1:0]          act_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [SITE_W-1:0]            site_raw_reg;
    logic                         idx_ok_reg;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [CAP_W-1:0]             cap_reg;

    // scan pipeline
    logic             issuing_reg;
    logic [LIM_W-1:0] scan_idx_reg;
    logic [LIM_W-1:0] scan_idx_next;
    logic [CMP_W-1:0] lim_wide;
    logic [LIM_W-1:0] scan_limit;
    logic             s1_live_reg;
    logic             s2_live_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_entry_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0] adx;
    logic [DIFF_W-1:0] ady;
    logic [DIST_W-1:0] dist_sum;

    entry_t            s2_entry_reg;
    logic [DIST_W-1:0] s2_dist_reg;
    logic              s2_elig_reg;
    logic [IDX_W-1:0]  s2_idx_reg;

    logic              have_reg;
    entry_t            best_entry_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              closer;
    logic              take_best;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic              res_found_reg;
    logic [SITE_W-1:0] res_site_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [SITE_W-1:0] out_site_reg;
    logic [CNT_W-1:0]  out_count_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sites_in_use_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            sites_in_use_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            act_reg      <= in_action;
            idx_reg      <= IDX_W'(in_site_index);
            site_raw_reg <= in_site_index;
            idx_ok_reg   <= (32'(in_site_index) < 32'(MAX_SITES));
            px_reg       <= COORD_BITS'(in_pos_x);
            py_reg       <= COORD_BITS'(in_pos_y);
            cap_reg      <= in_capacity;
        end
    end

    assign lim_wide = (CMP_W'(sites_in_use_reg) > CMP_W'(MAX_SITES)) ?
                      CMP_W'(MAX_SITES) : CMP_W'(sites_in_use_reg);
    assign scan_limit    = LIM_W'(lim_wide);
    assign scan_idx_next = scan_idx_reg + LIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg  <= 1'b0;
            scan_idx_reg <= '0;
            s1_live_reg  <= 1'b0;
            s2_live_reg  <= 1'b0;
        end
        else
        begin
            s1_live_reg <= issuing_reg;
            s2_live_reg <= s1_live_reg;
            if (cmd.scan_start)
            begin
                issuing_reg  <= (scan_limit != '0);
                scan_idx_reg <= '0;
            end
            else if (issuing_reg)
            begin
                scan_idx_reg <= scan_idx_next;
                if (scan_idx_next == scan_limit)
                begin
                    issuing_reg <= 1'b0;
                end
            end
        end
    end

    // table read port
    assign rd_en   = issuing_reg | cmd.rd_site;
    assign rd_addr = issuing_reg ? scan_idx_reg[IDX_W-1:0] : idx_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
            rd_vld_reg   <= vld_reg[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    // manhattan distance
    assign dx  = {rd_entry_reg.x[COORD_BITS-1], rd_entry_reg.x} -
                 {px_reg[COORD_BITS-1], px_reg};
    assign dy  = {rd_entry_reg.y[COORD_BITS-1], rd_entry_reg.y} -
                 {py_reg[COORD_BITS-1], py_reg};
    assign adx = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
    assign ady = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
    assign dist_sum = DIST_W'(adx) + DIST_W'(ady);

    always_ff @(posedge clk)
    begin
        s2_entry_reg <= rd_entry_reg;
        s2_dist_reg  <= dist_sum;
        s2_elig_reg  <= rd_vld_reg && (rd_entry_reg.cap > rd_entry_reg.occ);
        s2_idx_reg   <= rd_idx_reg;
    end

    // tie-break: smaller x, then smaller y, then first seen
    assign closer = (s2_dist_reg < best_dist_reg) ||
                    ((s2_dist_reg == best_dist_reg) &&
                     ($signed(s2_entry_reg.x) < $signed(best_entry_reg.x))) ||
                    ((s2_dist_reg == best_dist_reg) &&
                     (s2_entry_reg.x == best_entry_reg.x) &&
                     ($signed(s2_entry_reg.y) < $signed(best_entry_reg.y)));
    assign take_best = s2_live_reg && s2_elig_reg && (!have_reg || closer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            have_reg <= 1'b0;
        end
        else if (take_best)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_entry_reg <= s2_entry_reg;
            best_dist_reg  <= s2_dist_reg;
            best_idx_reg   <= s2_idx_reg;
        end
    end

    // table write port
    assign wr_en   = cmd.wr_load | (cmd.wr_commit & have_reg);
    assign wr_addr = cmd.wr_load ? idx_reg : best_idx_reg;

    always_comb
    begin
        if (cmd.wr_load)
        begin
            wr_data.x   = px_reg;
            wr_data.y   = py_reg;
            wr_data.cap = cap_reg;
            wr_data.occ = '0;
        end
        else
        begin
            wr_data     = best_entry_reg;
            wr_data.occ = best_entry_reg.occ + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.wr_load)
        begin
            vld_reg[idx_reg] <= 1'b1;
        end
    end

    // result
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            case (cmd.res_sel)
                RES_LOAD:
                begin
                    res_found_reg <= 1'b1;
                    res_site_reg  <= site_raw_reg;
                    res_count_reg <= '0;
                end
                RES_READ:
                begin
                    res_found_reg <= 1'b1;
                    res_site_reg  <= site_raw_reg;
                    res_count_reg <= rd_vld_reg ? rd_entry_reg.occ : '0;
                end
                RES_COMMIT:
                begin
                    res_found_reg <= have_reg;
                    res_site_reg  <= have_reg ? SITE_W'(best_idx_reg) : '0;
                    res_count_reg <= have_reg ? (best_entry_reg.occ + CNT_W'(1)) : '0;
                end
                default:
                begin
                    res_found_reg <= 1'b0;
                    res_site_reg  <= '0;
                    res_count_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_site_reg  <= res_site_reg;
            out_count_reg <= res_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_site  = out_site_reg;
    assign out_count = out_count_reg;

    assign status.action    = act_reg;
    assign status.idx_ok    = idx_ok_reg;
    assign status.scan_busy = issuing_reg | s1_live_reg | s2_live_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

endmodule

FILE: hw/rtl/nearest_free_slot_allocator.sv
// Nearest free slot allocator.
// Input stream s_*: one request per handshake; s_tuser is the action
// (load site, place, read count), s_tdata carries site index, x, y, capacity.
// Output stream m_*: exactly one result per request; m_tuser is the found
// flag, m_tdata carries the site index and its occupancy count.
// cfg_wr_en/cfg_wr_data set the number of sites searched; write only while idle.
// A place scans the site table one entry per cycle through a single read
// port, followed by a two stage distance and compare pipeline, then the
// incremented count is written back. A new request is accepted from the
// cycle after the previous result is loaded into the output register.
// Reset clears the search count and all site valid flags; no clearing pass
// is needed. When the receiver stalls, the result holds in the output
// register, the block still accepts one more request and finishes it, then
// waits until the output register frees.
module nearest_free_slot_allocator
    import nfsa_pkg::*;
#(
    parameter int MAX_SITES  = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,   // site_index, pos_x, pos_y, capacity, zero pad
    input  logic [1:0]        s_tuser,   // action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // chosen_site, site_count, zero pad
    output logic              m_tuser    // found
);

    nfsa_cmd_t    cmd;
    nfsa_status_t status;

    logic              out_found;
    logic [SITE_W-1:0] out_site;
    logic [CNT_W-1:0]  out_count;

    nfsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nfsa_datapath #(
        .MAX_SITES  (MAX_SITES),
        .COORD_BITS (COORD_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_action     (s_tuser),
        .in_site_index (s_tdata[3:0]),
        .in_pos_x      ($signed(s_tdata[19:4])),
        .in_pos_y      ($signed(s_tdata[35:20])),
        .in_capacity   (s_tdata[51:36]),
        .m_tready      (m_tready),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (m_tvalid),
        .out_found     (out_found),
        .out_site      (out_site),
        .out_count     (out_count)
    );

    assign m_tdata = {4'b0000, out_count, out_site};
    assign m_tuser = out_found;

endmodule

FILE: tb/tb_nearest_free_slot_allocator.sv
`timescale 1ns / 1ps

module tb_nearest_free_slot_allocator;
    import nfsa_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int NUM_SITES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 90;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [SITE_W-1:0]   idx;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [CAP_W-1:0]    cap;
    } slot_req_t;

    typedef struct packed {
        logic              found;
        logic [SITE_W-1:0] site;
        logic [CNT_W-1:0]  count;
    } slot_result_t;

    typedef struct packed {
        logic              cfg_set;
        logic [CFG_W-1:0]  cfg_val;
        logic [ACTION_W-1:0] act;
        logic [SITE_W-1:0] idx;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [CAP_W-1:0]  cap;
        logic              chk;
        logic              e_found;
        logic [SITE_W-1:0] e_site;
        logic [CNT_W-1:0]  e_count;
    } directed_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [55:0]      s_tdata;   // site_index, pos_x, pos_y, capacity, zero pad
    logic [1:0]       s_tuser;   // action
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;   // chosen_site, site_count, zero pad
    logic             m_tuser;   // found

    nearest_free_slot_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the site table
    logic signed [POS_W-1:0] site_x   [NUM_SITES];
    logic signed [POS_W-1:0] site_y   [NUM_SITES];
    logic [CAP_W-1:0]        site_cap [NUM_SITES];
    logic [CNT_W-1:0]        site_occ [NUM_SITES];
    logic [CFG_W-1:0]        search_span;

    slot_result_t expected_results [$];
    slot_result_t typed_result;
    logic         use_typed;

    int errors;
    int cycles;
    int send_pct;
    int recv_pct;
    int n_loads;
    int n_placed;
    int n_no_free;
    int n_reads;
    int n_unused;
    int n_spans;

    directed_row_t directed_rows [23] = '{
        '{1'b0, 5'd0, ACT_READ,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_PLACE, 4'd0,  16'h8000, 16'h7fff, 16'h0000, 1'b1, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_NONE,  4'd15, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd15, 16'h7fff, 16'h8000, 16'hffff, 1'b1, 1'b1, 4'd15, 16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd0,  16'h8000, 16'h7fff, 16'h0001, 1'b1, 1'b1, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd1,  16'h7fff, 16'h8000, 16'h0002, 1'b1, 1'b1, 4'd1,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd2,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd2,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd3,  16'h0005, 16'h0005, 16'h0003, 1'b1, 1'b1, 4'd3,  16'd0},
        '{1'b1, 5'd4, ACT_PLACE, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_PLACE, 4'd0,  16'h8000, 16'h7fff, 16'h0000, 1'b1, 1'b1, 4'd0,  16'd1},
        '{1'b0, 5'd0, ACT_PLACE, 4'd0,  16'h8000, 16'h7fff, 16'h0000, 1'b0, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd4,  16'hffff, 16'h0001, 16'h0002, 1'b1, 1'b1, 4'd4,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd5,  16'h0001, 16'hffff, 16'h0002, 1'b1, 1'b1, 4'd5,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd6,  16'hffff, 16'hffff, 16'h0002, 1'b1, 1'b1, 4'd6,  16'd0},
        '{1'b1, 5'd7, ACT_PLACE, 4'd9,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_PLACE, 4'd0,  16'h0000, 16'h0000, 16'hffff, 1'b0, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_READ,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd0,  16'd1},
        '{1'b0, 5'd0, ACT_READ,  4'd15, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1, 4'd15, 16'd0},
        '{1'b1, 5'd1, ACT_PLACE, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_LOAD,  4'd0,  16'h1234, 16'hedcb, 16'h0005, 1'b1, 1'b1, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_READ,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_PLACE, 4'd0,  16'h7fff, 16'h7fff, 16'h0000, 1'b0, 1'b0, 4'd0,  16'd0},
        '{1'b0, 5'd0, ACT_NONE,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0,  16'd0}
    };

    // updates the shadow table and returns the result the block must give
    function automatic slot_result_t apply_request(input slot_req_t r);
        slot_result_t res;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        int limit;
        int best;
        int best_d;
        int dx;
        int dy;
        int d;
        logic have;
        res = '0;
        px = r.x;
        py = r.y;
        case (r.act)
            ACT_LOAD:
            begin
                site_x[r.idx] = px;
                site_y[r.idx] = py;
                site_cap[r.idx] = r.cap;
                site_occ[r.idx] = '0;
                res.found = 1'b1;
                res.site = r.idx;
                n_loads++;
            end
            ACT_PLACE:
            begin
                limit = (search_span > NUM_SITES) ? NUM_SITES : int'(search_span);
                have = 1'b0;
                best = 0;
                best_d = 0;
                for (int i = 0; i < limit; i++)
                begin
                    if (site_cap[i] > site_occ[i])
                    begin
                        dx = int'(px) - int'(site_x[i]);
                        dy = int'(py) - int'(site_y[i]);
                        if (dx < 0)
                            dx = -dx;
                        if (dy < 0)
                            dy = -dy;
                        d = dx + dy;
                        if (!have || d < best_d
                            || (d == best_d && site_x[i] < site_x[best])
                            || (d == best_d && site_x[i] == site_x[best]
                                && site_y[i] < site_y[best]))
                        begin
                            have = 1'b1;
                            best = i;
                            best_d = d;
                        end
                    end
                end
                if (have)
                begin
                    site_occ[best] = site_occ[best] + 1'b1;
                    res.found = 1'b1;
                    res.site = best[SITE_W-1:0];
                    res.count = site_occ[best];
                    n_placed++;
                end
                else
                    n_no_free++;
            end
            ACT_READ:
            begin
                res.found = 1'b1;
                res.site = r.idx;
                res.count = site_occ[r.idx];
                n_reads++;
            end
            default:
                n_unused++;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // request acceptance and result check
    always @(posedge clk)
    begin
        slot_result_t want;
        slot_result_t got;
        slot_req_t r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                r.act = s_tuser;
                r.idx = s_tdata[3:0];
                r.x = s_tdata[19:4];
                r.y = s_tdata[35:20];
                r.cap = s_tdata[51:36];
                want = apply_request(r);
                expected_results.push_back(use_typed ? typed_result : want);
            end
            if (m_tvalid && m_tready)
            begin
                got.found = m_tuser;
                got.site = m_tdata[3:0];
                got.count = m_tdata[19:4];
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with nothing pending (site %0d)",
                                              got.site));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                                                  got.found, want.found));
                    if (got.site !== want.site)
                        report_mismatch($sformatf("chosen_site got %0d want %0d",
                                                  got.site, want.site));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("site_count got %0d want %0d",
                                                  got.count, want.count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_nearest_free_slot_allocator: errors");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) < recv_pct) ? 1'b0 : 1'b1;

    task automatic push_request(input slot_req_t r);
        while ($urandom_range(99) < send_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.act;
        s_tdata <= {4'b0, r.cap, r.y, r.x, r.idx};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain(input int hold);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (hold) @(negedge clk);
    endtask

    task automatic write_span(input logic [CFG_W-1:0] val);
        drain(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        search_span = val;
        n_spans++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_coord();
        int v;
        case ($urandom_range(3))
            0:
            begin
                v = int'($urandom_range(16)) - 8;
                return v[POS_W-1:0];
            end
            1:
            begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            default:
                return POS_W'($urandom);
        endcase
    endfunction

    function automatic slot_req_t random_request();
        slot_req_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            r.act = ACT_LOAD;
        else if (pick < 80)
            r.act = ACT_PLACE;
        else if (pick < 95)
            r.act = ACT_READ;
        else
            r.act = ACT_NONE;
        r.idx = SITE_W'($urandom);
        r.x = pick_coord();
        r.y = pick_coord();
        case ($urandom_range(9))
            0: r.cap = 16'h0000;
            1: r.cap = 16'hffff;
            2: r.cap = CAP_W'($urandom);
            default: r.cap = 16'($urandom_range(4, 1));
        endcase
        return r;
    endfunction

    logic [CFG_W-1:0] phase_spans [8] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd9, 5'd16, 5'd17, 5'd5};

    initial
    begin
        slot_req_t r;
        directed_row_t row;
        errors = 0;
        cycles = 0;
        send_pct = 0;
        recv_pct = 0;
        n_loads = 0;
        n_placed = 0;
        n_no_free = 0;
        n_reads = 0;
        n_unused = 0;
        n_spans = 0;
        use_typed = 1'b0;
        typed_result = '0;
        search_span = '0;
        for (int i = 0; i < NUM_SITES; i++)
        begin
            site_x[i] = '0;
            site_y[i] = '0;
            site_cap[i] = '0;
            site_occ[i] = '0;
        end
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed checks
        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.cfg_set)
                write_span(row.cfg_val);
            use_typed = row.chk;
            typed_result = {row.e_found, row.e_site, row.e_count};
            r = {row.act, row.idx, row.x, row.y, row.cap};
            push_request(r);
        end
        use_typed = 1'b0;

        // give every site coordinates before wide searches
        for (int i = 0; i < NUM_SITES; i++)
        begin
            r = random_request();
            r.act = ACT_LOAD;
            r.idx = i[SITE_W-1:0];
            push_request(r);
        end

        for (int p = 0; p < 8; p++)
        begin
            send_pct = 0;
            recv_pct = 0;
            write_span((p == 7) ? 5'($urandom_range(31)) : phase_spans[p]);
            case (p % 4)
                1: send_pct = 71;
                2: recv_pct = 71;
                3:
                begin
                    send_pct = 21;
                    recv_pct = 21;
                end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain(1 + $urandom_range(4));
                push_request(random_request());
            end
        end

        send_pct = 0;
        drain(SETTLE_CYCLES);
        recv_pct = 0;
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("covered %0d loads, %0d placements, %0d with no free site, %0d count reads,",
                 n_loads, n_placed, n_no_free, n_reads);
        $display("%0d unused actions, across %0d search spans and four stall patterns",
                 n_unused, n_spans);
        if (errors == 0)
            $display("tb_nearest_free_slot_allocator: clean");
        else
            $display("tb_nearest_free_slot_allocator: errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/nfsa_pkg.sv
hw/rtl/nfsa_ctrl.sv
hw/rtl/nfsa_datapath.sv
hw/rtl/nearest_free_slot_allocator.sv
tb/tb_nearest_free_slot_allocator.sv
